// File: design/ibfr_pkg.sv
// ============================================================================
// ibfr_pkg
// Shared constants and types for the serial-bus frame receiver.
// ============================================================================
package ibfr_pkg;

    // Frame layout
    localparam int CHANNELS    = 14;
    localparam int FRAME_BYTES = 32;
    localparam int SUM_BYTES   = 30;
    localparam int BYTE_AW     = $clog2(FRAME_BYTES);
    localparam int WORD_AW     = $clog2(FRAME_BYTES / 2);
    localparam int CH_W        = 4;

    // Header bytes
    localparam logic [7:0] HDR_LEN = 8'h20;
    localparam logic [7:0] HDR_CMD = 8'h40;

    // Result kinds
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Request operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_CHANNEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_THRESH  = 3'd4;

    // Commands from the frame parser to the emitter
    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_ERROR,
        CMD_STATUS
    } cmd_op_t;

    typedef struct packed {
        logic    valid;
        cmd_op_t op;
        logic    healthy;
    } cmd_t;

    // Configuration seen by the emitter
    typedef struct packed {
        logic [15:0]     pulse_min;
        logic [15:0]     pulse_max;
        logic [CH_W-1:0] arm_channel;
        logic [15:0]     arm_threshold;
    } emit_cfg_t;

endpackage

// File: design/ibfr_if.sv
// ============================================================================
// ibfr_if
// Valid/ready channel interfaces for incoming requests and result items.
// ============================================================================
interface ibfr_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface ibfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [15:0] value_us;
    logic [15:0] raw_value;
    logic        healthy;
    logic        armed;
    logic        last;

    modport source (output valid, output kind, output channel, output value_us,
                    output raw_value, output healthy, output armed, output last,
                    input ready);
    modport sink   (input valid, input kind, input channel, input value_us,
                    input raw_value, input healthy, input armed, input last,
                    output ready);
endinterface

// File: design/ibus_frame_receiver.sv
// ============================================================================
// ibus_frame_receiver
// Serial-bus frame receiver: header sync, frame gathering with a running
// checksum, fourteen-channel readout and link health on millisecond ticks.
// ============================================================================
//
// Channel   Dir   Carries
// --------  ----  -------------------------------------------------------
// item      in    op (byte or tick), data_byte
// result    out   kind, channel, value_us, raw_value, healthy, armed, last
// cfg_*     in    write enable, register index, 16-bit write data
//
// A byte or tick request is taken whenever the emitter is idle. A completed valid frame
// keeps item.ready low through the channel readout: each channel costs one frame-store
// read and one load of the result register, more while result.ready is low.
// A checksum error or a status item holds the input until its item is loaded, longer while
// an earlier result still waits.
// The result register lets a request be taken while a result still waits.
// Reset is asynchronous and active low; the frame store needs no clearing.
module ibus_frame_receiver
    import ibfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    ibfr_item_if.sink            item,
    ibfr_result_if.source        result
);

    // Configuration registers
    logic [15:0]     pulse_min_reg;
    logic [15:0]     pulse_max_reg;
    logic [15:0]     stale_tmo_reg;
    logic [CH_W-1:0] arm_channel_reg;
    logic [15:0]     arm_thresh_reg;

    // Parser state
    logic [BYTE_AW-1:0] byte_index_reg, byte_index_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         csum_lo_reg, csum_lo_next;
    logic               frame_seen_reg, frame_seen_next;
    logic [15:0]        age_reg, age_next;

    logic               accept;
    logic               emit_busy;
    cmd_t               cmd;
    emit_cfg_t          emit_cfg;

    logic               ram_we;
    logic [BYTE_AW-1:0] ram_waddr;
    logic               ram_re;
    logic [WORD_AW-1:0] ram_raddr;
    logic [15:0]        ram_rdata;
    logic [15:0]        expect_sum;

    assign item.ready = !emit_busy;
    assign accept     = item.valid && item.ready;
    assign expect_sum = 16'hFFFF - sum_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg   <= 16'd1000;
            pulse_max_reg   <= 16'd2000;
            stale_tmo_reg   <= 16'd100;
            arm_channel_reg <= CH_W'(4);
            arm_thresh_reg  <= 16'd1500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULSE_MIN:   pulse_min_reg   <= cfg_data;
                REG_PULSE_MAX:   pulse_max_reg   <= cfg_data;
                REG_STALE_TMO:   stale_tmo_reg   <= cfg_data;
                REG_ARM_CHANNEL: arm_channel_reg <= cfg_data[CH_W-1:0];
                REG_ARM_THRESH:  arm_thresh_reg  <= cfg_data;
                default:         arm_thresh_reg  <= arm_thresh_reg;
            endcase
        end
    end

    // Header sync, byte store, running checksum and frame age.
    always_comb
    begin
        byte_index_next = byte_index_reg;
        sum_next        = sum_reg;
        csum_lo_next    = csum_lo_reg;
        frame_seen_next = frame_seen_reg;
        age_next        = age_reg;
        ram_we          = 1'b0;
        ram_waddr       = byte_index_reg;
        cmd             = '{valid: 1'b0, op: CMD_STATUS, healthy: 1'b0};

        if (accept)
        begin
            if (item.op == OP_TICK)
            begin
                if (age_reg != 16'hFFFF)
                begin
                    age_next = age_reg + 16'd1;
                end
                cmd.valid   = 1'b1;
                cmd.op      = CMD_STATUS;
                cmd.healthy = frame_seen_reg && (age_next <= stale_tmo_reg);
            end
            else if (byte_index_reg == '0)
            begin
                // Wait for the length byte that opens a frame.
                if (item.data_byte == HDR_LEN)
                begin
                    ram_we          = 1'b1;
                    sum_next        = {8'h00, item.data_byte};
                    byte_index_next = BYTE_AW'(1);
                end
            end
            else if (byte_index_reg == BYTE_AW'(1) && item.data_byte != HDR_CMD)
            begin
                // A second length byte restarts the frame at byte one.
                if (item.data_byte == HDR_LEN)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = '0;
                    sum_next        = {8'h00, item.data_byte};
                    byte_index_next = BYTE_AW'(1);
                end
                else
                begin
                    byte_index_next = '0;
                end
            end
            else
            begin
                ram_we          = 1'b1;
                byte_index_next = byte_index_reg + BYTE_AW'(1);
                if (byte_index_reg < BYTE_AW'(SUM_BYTES))
                begin
                    sum_next = sum_reg + {8'h00, item.data_byte};
                end
                if (byte_index_reg == BYTE_AW'(SUM_BYTES))
                begin
                    csum_lo_next = item.data_byte;
                end
                // The final byte completes the frame and the checksum.
                if (byte_index_reg == BYTE_AW'(FRAME_BYTES - 1))
                begin
                    cmd.valid = 1'b1;
                    if (expect_sum == {item.data_byte, csum_lo_reg})
                    begin
                        cmd.op          = CMD_FRAME;
                        frame_seen_next = 1'b1;
                        age_next        = '0;
                    end
                    else
                    begin
                        cmd.op = CMD_ERROR;
                    end
                end
            end
        end
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
            csum_lo_reg    <= '0;
            frame_seen_reg <= 1'b0;
            age_reg        <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            sum_reg        <= sum_next;
            csum_lo_reg    <= csum_lo_next;
            frame_seen_reg <= frame_seen_next;
            age_reg        <= age_next;
        end
    end

    assign emit_cfg = '{pulse_min:     pulse_min_reg,
                        pulse_max:     pulse_max_reg,
                        arm_channel:   arm_channel_reg,
                        arm_threshold: arm_thresh_reg};

    // Frame store.
    ibfr_frame_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result sequencing.
    ibfr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (emit_cfg),
        .busy      (emit_busy),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

endmodule

// File: design/ibfr_frame_ram.sv
// ============================================================================
// ibfr_frame_ram
// Frame store: byte-wide writes, registered 16-bit word reads.
// ============================================================================
module ibfr_frame_ram
    import ibfr_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [BYTE_AW-1:0] waddr,
    input  logic [7:0]         wdata,
    input  logic               re,
    input  logic [WORD_AW-1:0] raddr,
    output logic [15:0]        rdata
);

    // Even bytes hold the low half of each word, odd bytes the high half.
    logic [7:0]  lo_mem [FRAME_BYTES/2];
    logic [7:0]  hi_mem [FRAME_BYTES/2];
    logic [15:0] rdata_reg;

    // Byte write into the lane chosen by the address LSB.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (waddr[0])
            begin
                hi_mem[waddr[BYTE_AW-1:1]] <= wdata;
            end
            else
            begin
                lo_mem[waddr[BYTE_AW-1:1]] <= wdata;
            end
        end
    end

    // Registered word read; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= {hi_mem[raddr], lo_mem[raddr]};
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/ibfr_emitter.sv
// ============================================================================
// ibfr_emitter
// Reads channel words back from the frame store, clamps them and drives the
// result register; also issues checksum error and link status items.
// ============================================================================
module ibfr_emitter
    import ibfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  emit_cfg_t           cfg,
    output logic                busy,
    output logic                ram_re,
    output logic [WORD_AW-1:0]  ram_raddr,
    input  logic [15:0]         ram_rdata,
    ibfr_result_if.source       result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_READ,
        ST_WAIT
    } state_t;

    state_t          state_reg;
    logic [CH_W-1:0] ch_reg;
    logic [15:0]     arm_value_reg;
    logic [1:0]      single_kind_reg;
    logic            single_healthy_reg;

    logic            out_valid_reg;
    logic [1:0]      out_kind_reg;
    logic [3:0]      out_channel_reg;
    logic [15:0]     out_value_reg;
    logic [15:0]     out_raw_reg;
    logic            out_healthy_reg;
    logic            out_armed_reg;
    logic            out_last_reg;

    logic            can_load;
    logic            out_load;
    logic [CH_W-1:0] arm_sel;
    logic [15:0]     clamped;
    logic            last_ch;

    // The result register may be refilled when empty or being drained.
    assign can_load = !out_valid_reg || result.ready;

    // A new item goes into the result register this cycle.
    assign out_load = can_load && ((state_reg == ST_SINGLE) || (state_reg == ST_WAIT));

    // Out-of-range arm channel selects the last channel.
    assign arm_sel = (cfg.arm_channel >= CH_W'(CHANNELS)) ? CH_W'(CHANNELS - 1)
                                                           : cfg.arm_channel;

    // Clamp: the lower bound is checked first and wins whenever the value lies below it.
    always_comb
    begin
        if (ram_rdata < cfg.pulse_min)
        begin
            clamped = cfg.pulse_min;
        end
        else if (ram_rdata > cfg.pulse_max)
        begin
            clamped = cfg.pulse_max;
        end
        else
        begin
            clamped = ram_rdata;
        end
    end

    assign last_ch   = (ch_reg == CH_W'(CHANNELS - 1));
    assign busy      = (state_reg != ST_IDLE);
    assign ram_re    = (state_reg == ST_READ);
    // Channel n sits in word n + 1, after the two header bytes.
    assign ram_raddr = WORD_AW'(ch_reg) + WORD_AW'(1);

    // Sequencer, arm capture and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            ch_reg             <= '0;
            arm_value_reg      <= '0;
            single_kind_reg    <= KIND_ERROR;
            single_healthy_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_kind_reg       <= KIND_CHANNEL;
            out_channel_reg    <= '0;
            out_value_reg      <= '0;
            out_raw_reg        <= '0;
            out_healthy_reg    <= 1'b0;
            out_armed_reg      <= 1'b0;
            out_last_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        unique case (cmd.op)
                            CMD_FRAME:
                            begin
                                ch_reg    <= '0;
                                state_reg <= ST_READ;
                            end
                            CMD_ERROR:
                            begin
                                single_kind_reg    <= KIND_ERROR;
                                single_healthy_reg <= 1'b0;
                                state_reg          <= ST_SINGLE;
                            end
                            CMD_STATUS:
                            begin
                                single_kind_reg    <= KIND_STATUS;
                                single_healthy_reg <= cmd.healthy;
                                state_reg          <= ST_SINGLE;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_SINGLE:
                begin
                    if (can_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_kind_reg    <= single_kind_reg;
                        out_channel_reg <= '0;
                        out_value_reg   <= '0;
                        out_raw_reg     <= '0;
                        out_healthy_reg <= single_healthy_reg;
                        out_armed_reg   <= single_healthy_reg &&
                                           (arm_value_reg >= cfg.arm_threshold);
                        out_last_reg    <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_WAIT;
                end

                ST_WAIT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_kind_reg    <= KIND_CHANNEL;
                        out_channel_reg <= 4'(ch_reg);
                        out_value_reg   <= clamped;
                        out_raw_reg     <= ram_rdata;
                        out_healthy_reg <= 1'b0;
                        out_armed_reg   <= 1'b0;
                        out_last_reg    <= last_ch;
                        if (ch_reg == arm_sel)
                        begin
                            arm_value_reg <= clamped;
                        end
                        if (last_ch)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_kind_reg;
    assign result.channel   = out_channel_reg;
    assign result.value_us  = out_value_reg;
    assign result.raw_value = out_raw_reg;
    assign result.healthy   = out_healthy_reg;
    assign result.armed     = out_armed_reg;
    assign result.last      = out_last_reg;

endmodule

// File: verif/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the serial-bus frame receiver. Requests (bytes and
// millisecond ticks) go in on a valid/ready channel. A predictor inside the
// bench works out the channel, checksum-error and link-status items that each
// request should produce, and every result taken from the block is compared
// field by field. The run steps through several register settings, crossed
// and open clamp limits among them, and lets the link go stale on ticks.
// ============================================================================
module tb_top;
    import ibfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel;
        logic [15:0] value_us;
        logic [15:0] raw_value;
        logic        healthy;
        logic        armed;
        logic        last;
    } link_item_t;

    // Decodes accepted requests into the items the receiver owes and
    // matches them against what it actually returns.
    class frame_decoder_check;
        link_item_t  due_items [$];
        logic [7:0]  store [FRAME_BYTES];
        logic [4:0]  byte_pos;
        bit          seen;
        logic [15:0] age;
        logic [15:0] arm_val;
        logic [15:0] pmin;
        logic [15:0] pmax;
        logic [15:0] stale_ms;
        logic [3:0]  arm_ch;
        logic [15:0] arm_thr;
        int          errors;
        int          n_requests;
        int          n_good;
        int          n_bad;
        int          n_status;

        function new();
            byte_pos = '0;
            seen     = 0;
            age      = '0;
            arm_val  = '0;
            pmin     = 16'd1000;
            pmax     = 16'd2000;
            stale_ms = 16'd100;
            arm_ch   = 4'd4;
            arm_thr  = 16'd1500;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] r, logic [15:0] v);
            case (r)
                REG_PULSE_MIN:   pmin     = v;
                REG_PULSE_MAX:   pmax     = v;
                REG_STALE_TMO:   stale_ms = v;
                REG_ARM_CHANNEL: arm_ch   = v[3:0];
                REG_ARM_THRESH:  arm_thr  = v;
                default: ;
            endcase
        endfunction

        // Lower bound is checked first; when the limits cross it wins for values below it.
        function logic [15:0] clamp(logic [15:0] v);
            if (v < pmin)
            begin
                return pmin;
            end
            if (v > pmax)
            begin
                return pmax;
            end
            return v;
        endfunction

        function void push(logic [1:0] k, logic [3:0] ch, logic [15:0] val,
                           logic [15:0] raw, logic hl, logic ar, logic lst);
            link_item_t it;
            it.kind      = k;
            it.channel   = ch;
            it.value_us  = val;
            it.raw_value = raw;
            it.healthy   = hl;
            it.armed     = ar;
            it.last      = lst;
            due_items.push_back(it);
        endfunction

        // A complete frame either yields fourteen channel items or one error.
        function void close_frame();
            logic [15:0] sum_want;
            logic [15:0] sum_got;
            logic [15:0] raw;
            logic [15:0] clamped;
            int          sel;
            sum_want = 16'hFFFF;
            for (int i = 0; i < SUM_BYTES; i++)
            begin
                sum_want = sum_want - 16'(store[i]);
            end
            sum_got = {store[SUM_BYTES+1], store[SUM_BYTES]};
            if (sum_want != sum_got)
            begin
                push(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                n_bad++;
                return;
            end
            sel = (arm_ch >= CHANNELS) ? CHANNELS - 1 : int'(arm_ch);
            for (int i = 0; i < CHANNELS; i++)
            begin
                raw     = {store[3 + 2*i], store[2 + 2*i]};
                clamped = clamp(raw);
                if (i == sel)
                begin
                    arm_val = clamped;
                end
                push(KIND_CHANNEL, 4'(i), clamped, raw, 1'b0, 1'b0,
                     (i == CHANNELS - 1));
            end
            seen = 1;
            age  = '0;
            n_good++;
        endfunction

        function void note_request(logic op, logic [7:0] b);
            logic hl;
            n_requests++;
            if (op == OP_TICK)
            begin
                if (age != 16'hFFFF)
                begin
                    age = age + 16'd1;
                end
                hl = seen && (age <= stale_ms);
                push(KIND_STATUS, '0, '0, '0, hl, hl && (arm_val >= arm_thr), 1'b1);
                n_status++;
                return;
            end
            // Header synchronisation on the first two bytes.
            if (byte_pos == 5'd0 && b != HDR_LEN)
            begin
                return;
            end
            if (byte_pos == 5'd1 && b != HDR_CMD)
            begin
                if (b == HDR_LEN)
                begin
                    store[0] = b;
                    byte_pos = 5'd1;
                end
                else
                begin
                    byte_pos = 5'd0;
                end
                return;
            end
            store[byte_pos] = b;
            byte_pos = byte_pos + 5'd1;
            if (byte_pos == 5'd0)
            begin
                close_frame();
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(link_item_t got);
            link_item_t want;
            if (due_items.size() == 0)
            begin
                $error("unexpected result: kind %0d channel %0d", got.kind, got.channel);
                errors++;
                return;
            end
            want = due_items.pop_front();
            compare("kind", 16'(want.kind), 16'(got.kind));
            compare("channel", 16'(want.channel), 16'(got.channel));
            compare("value_us", want.value_us, got.value_us);
            compare("raw_value", want.raw_value, got.raw_value);
            compare("healthy", 16'(want.healthy), 16'(got.healthy));
            compare("armed", 16'(want.armed), 16'(got.armed));
            compare("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    ibfr_item_if   req_bus ();
    ibfr_result_if res_bus ();

    frame_decoder_check chk = new();

    int  burst_left = 0;
    bit  full_rate  = 0;
    int  hold_req   = 0;

    ibus_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (req_bus),
        .result    (res_bus)
    );

    // 4 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Result side: take items and vary ready on a pattern of its own,
    // with an occasional long hold-off on request from the stimulus.
    initial
    begin
        link_item_t got;
        int         hold_left;
        int         rx_mode;
        int         rx_cyc;
        int         rx_period;
        int         rx_on;
        logic       rdy;
        hold_left = 0;
        rx_mode   = 0;
        rx_cyc    = 0;
        rx_period = 4;
        rx_on     = 2;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                got.kind      = res_bus.kind;
                got.channel   = res_bus.channel;
                got.value_us  = res_bus.value_us;
                got.raw_value = res_bus.raw_value;
                got.healthy   = res_bus.healthy;
                got.armed     = res_bus.armed;
                got.last      = res_bus.last;
                chk.check_result(got);
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            rx_cyc++;
            if (rx_cyc % 128 == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                rx_period = $urandom_range(2, 9);
                rx_on     = $urandom_range(1, rx_period);
            end
            if (hold_left > 0)
            begin
                rdy = 1'b0;
                hold_left--;
            end
            else if (full_rate)
            begin
                rdy = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = ((rx_cyc % rx_period) < rx_on);
                endcase
            end
            res_bus.ready <= rdy;
        end
    end

    // Offer one request, in bursts with random gaps, and wait for it to be taken.
    task automatic send_req(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = full_rate ? 1 : $urandom_range(1, 24);
            gap = (full_rate || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_bus.valid     <= 1'b1;
        req_bus.op        <= op;
        req_bus.data_byte <= b;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        chk.note_request(op, b);
        burst_left--;
    endtask

    // Build a frame from fourteen channel words, optionally spoiling the
    // checksum and slipping ticks in between bytes.
    task automatic send_frame(input logic [15:0] words [CHANNELS], input bit bad_sum,
                              input bit with_ticks);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] csum;
        fb[0] = HDR_LEN;
        fb[1] = HDR_CMD;
        for (int i = 0; i < CHANNELS; i++)
        begin
            fb[2 + 2*i] = words[i][7:0];
            fb[3 + 2*i] = words[i][15:8];
        end
        csum = 16'hFFFF;
        for (int i = 0; i < SUM_BYTES; i++)
        begin
            csum = csum - 16'(fb[i]);
        end
        if (bad_sum)
        begin
            csum = csum ^ 16'($urandom_range(1, 65535));
        end
        fb[SUM_BYTES]     = csum[7:0];
        fb[SUM_BYTES + 1] = csum[15:8];
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (with_ticks && $urandom_range(0, 15) == 0)
            begin
                send_req(OP_TICK, 8'($urandom));
            end
            send_req(OP_BYTE, fb[i]);
        end
    endtask

    // Channel words biased towards the clamp limits and the full range.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(900, 2100));
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill out whatever partial frame is open so the next frame starts in step.
    task automatic realign();
        while (chk.byte_pos != 5'd0)
        begin
            send_req(OP_BYTE, 8'($urandom_range(0, 31)));
        end
    endtask

    // Stop offering and let every owed item drain, plus the block's own latency.
    task automatic settle();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (chk.due_items.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chk.set_reg(r, v);
    endtask

    task automatic write_all(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] stale, input logic [15:0] ch,
                             input logic [15:0] thr);
        write_reg(REG_PULSE_MIN, lo);
        write_reg(REG_PULSE_MAX, hi);
        write_reg(REG_STALE_TMO, stale);
        write_reg(REG_ARM_CHANNEL, ch);
        write_reg(REG_ARM_THRESH, thr);
    endtask

    // Mostly well-formed frames with random content, plus ticks, noise,
    // broken headers and truncated frames.
    task automatic random_traffic(input int count);
        logic [15:0] w [CHANNELS];
        int          start;
        start = chk.n_requests;
        while (chk.n_requests - start < count)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                w[i] = rand_word();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_frame(w, 1'b0, 1'($urandom_range(0, 1)));
                5:             send_frame(w, 1'b1, 1'($urandom_range(0, 1)));
                6:             repeat ($urandom_range(1, 5)) send_req(OP_TICK, 8'($urandom));
                7:             repeat ($urandom_range(1, 6)) send_req(OP_BYTE, 8'($urandom));
                8:
                begin
                    send_req(OP_BYTE, HDR_LEN);
                    send_req(OP_BYTE, $urandom_range(0, 1) ? HDR_LEN : 8'($urandom));
                end
                default:
                begin
                    send_req(OP_BYTE, HDR_LEN);
                    send_req(OP_BYTE, HDR_CMD);
                    repeat ($urandom_range(1, 20)) send_req(OP_BYTE, 8'($urandom));
                end
            endcase
            realign();
        end
    endtask

    initial
    begin
        logic [15:0] w [CHANNELS];
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_PULSE_MIN;
        cfg_data          = '0;
        req_bus.valid     = 1'b0;
        req_bus.op        = OP_BYTE;
        req_bus.data_byte = '0;
        res_bus.ready     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status before any frame, dropped bytes, both kinds of
        // restart at the second header byte, then a frame whose channels sit
        // on and around the default clamp limits and a spoiled copy of it.
        send_req(OP_TICK, 8'h00);
        send_req(OP_BYTE, 8'h55);
        send_req(OP_BYTE, HDR_CMD);
        send_req(OP_BYTE, HDR_LEN);
        send_req(OP_BYTE, 8'h41);
        send_req(OP_BYTE, HDR_LEN);
        for (int i = 0; i < CHANNELS; i++)
        begin
            w[i] = rand_word();
        end
        w[0] = 16'h0000;
        w[1] = 16'hFFFF;
        w[2] = 16'd999;
        w[3] = 16'd1000;
        w[4] = 16'd1500;
        w[5] = 16'd2000;
        w[6] = 16'd2001;
        w[7] = 16'h2040;
        w[8] = 16'h4020;
        send_frame(w, 1'b0, 1'b0);
        send_req(OP_TICK, 8'hFF);
        send_frame(w, 1'b1, 1'b0);
        send_req(OP_TICK, 8'h00);
        random_traffic(16);
        settle();

        // Open limits, zero timeout, first channel arms at any level.
        write_all(16'h0000, 16'hFFFF, 16'h0000, 16'd0, 16'h0000);
        random_traffic(24);
        settle();

        // Crossed limits, longest timeout, out-of-range arm channel.
        write_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'd15, 16'hFFFF);
        random_traffic(24);
        settle();

        // Realistic limits; the receiver holds off for a long stretch while
        // frames keep coming, so the block backs up into its input.
        write_all(16'($urandom_range(800, 1200)), 16'($urandom_range(1800, 2200)),
                  16'($urandom_range(1, 20)), 16'd13, 16'($urandom_range(1000, 2000)));
        hold_req = 300;
        random_traffic(24);
        settle();

        // Anything goes, short timeout, the other out-of-range arm channel.
        write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)), 16'd14,
                  16'($urandom));
        random_traffic(24);
        settle();

        write_all(16'd1000, 16'd2000, 16'd3, 16'($urandom_range(0, 15)), 16'd1500);
        random_traffic(24);
        settle();

        // A fresh frame, then ticks back to back until the link goes stale.
        write_reg(REG_STALE_TMO, 16'd5);
        for (int i = 0; i < CHANNELS; i++)
        begin
            w[i] = rand_word();
        end
        send_frame(w, 1'b0, 1'b0);
        full_rate = 1;
        repeat (10) send_req(OP_TICK, 8'($urandom));
        full_rate = 0;
        repeat (3) send_req(OP_TICK, 8'($urandom));
        settle();

        $display("summary: %0d requests, %0d frames decoded, %0d checksum failures, %0d link reports",
                 chk.n_requests, chk.n_good, chk.n_bad, chk.n_status);
        $display("summary: seven register settings incl. crossed and open limits, link going stale");
        if (chk.errors == 0 && chk.due_items.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
